// File: src/md5sh_pkg.sv
// ----------------------------------------------------------------------------
// MD5 stream hash package
// Round constants, rotation amounts, the initial vector and the round helper
// functions that the hash unit uses.
// ----------------------------------------------------------------------------
package md5sh_pkg;

   typedef logic [31:0] word_type;

   localparam int unsigned FinalStep     = 66;
   localparam int unsigned LastRoundStep = 65;
   localparam logic [5:0]  PadLenLimit   = 6'd55;
   localparam logic [7:0]  PadMarker     = 8'h80;

   localparam word_type InitVector [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam word_type RoundAdd [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] RotAmount [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   function automatic logic [3:0] msg_index(input logic [5:0] round);
      logic [3:0] low;
      low = round[3:0];
      case (round[5:4])
         2'd0:    msg_index = low;
         2'd1:    msg_index = 4'(low * 4'd5 + 4'd1);
         2'd2:    msg_index = 4'(low * 4'd3 + 4'd5);
         2'd3:    msg_index = 4'(low * 4'd7);
         default: msg_index = low;
      endcase
   endfunction

   function automatic word_type round_fn(input word_type b, input word_type c,
                                         input word_type d, input logic [1:0] sel);
      case (sel)
         2'd0:    round_fn = (b & c) | (~b & d);
         2'd1:    round_fn = (b & d) | (c & ~d);
         2'd2:    round_fn = b ^ c ^ d;
         2'd3:    round_fn = c ^ (b | ~d);
         default: round_fn = b ^ c ^ d;
      endcase
   endfunction

   function automatic word_type rotl(input word_type x, input logic [4:0] s);
      logic [63:0] dbl;
      dbl = {x, x} << s;
      rotl = dbl[63:32];
   endfunction

endpackage

// File: src/md5_stream_hash_unit.sv
// Byte beats are taken only while the unit is idle; each 64-byte block then runs
// through the compression loop, one MD5 round per cycle once the message word and pre-sum are prefetched.
// A last beat adds one or two such compressions before the digest beat appears.
// No new bytes are taken while a block is being compressed.
// Reset is synchronous: chaining words return to the initial vector and the
// counts clear; the block buffer is not cleared.
// ----------------------------------------------------------------------------
// MD5 stream hash unit
// Gathers message bytes into 32-bit words of a block buffer, compresses each
// block with one shared round unit and pads the message on the last beat.
// ----------------------------------------------------------------------------
module md5_stream_hash_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] data_byte
   input  logic                   req_tuser,   // [0] byte_present
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [127:0]           rsp_tdata    // digest_word0 up to digest_word3
);
   import md5sh_pkg::*;

   typedef enum logic {ST_IDLE, ST_RUN} state_type;
   typedef enum logic [1:0] {BLK_DATA, BLK_PAD_LAST, BLK_PAD_EXTRA, BLK_LEN_ONLY} block_type;

   state_type   state_ff;
   block_type   kind_ff;
   logic [6:0]  cnt_ff;
   logic        pend_last_ff;
   logic [5:0]  fill_ff;
   logic [54:0] blocks_ff;
   word_type    chain_ff [4];
   logic        rsp_valid_ff;

   word_type    a_ff, b_ff, c_ff, d_ff;
   word_type    pre_ff, rd_ff, alt_ff;
   logic        use_mem_ff;
   logic [23:0] acc_ff;
   logic [127:0] rsp_data_ff;
   word_type    mem [16];

   logic        accept, start, at_final, emit, restart, round_active;
   logic [5:0]  fill_in, n_eff;
   logic [5:0]  round_a, round_b, round_c;
   logic [3:0]  idx_a;
   logic        use_mem_in;
   word_type    alt_in, pad_word, w_b, a_src, pre_in, f_c, t_c;
   logic [63:0] bit_len;
   word_type    sum [4];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign fill_in    = fill_ff + 6'd1;
   assign n_eff      = req_tuser ? fill_in : fill_ff;
   assign start      = accept && ((req_tuser && (fill_ff == 6'h3f)) || req_tlast);

   assign at_final = (state_ff == ST_RUN) && (cnt_ff == 7'(FinalStep));
   assign emit     = at_final && (kind_ff inside {BLK_PAD_LAST, BLK_LEN_ONLY})
                     && (!rsp_valid_ff || rsp_tready);
   assign restart  = at_final && (kind_ff == BLK_PAD_EXTRA
                     || (kind_ff == BLK_DATA && pend_last_ff));
   assign round_active = (cnt_ff >= 7'd2) && (cnt_ff <= 7'(LastRoundStep));

   assign round_a = cnt_ff[5:0];
   assign round_b = cnt_ff[5:0] - 6'd1;
   assign round_c = cnt_ff[5:0] - 6'd2;
   assign idx_a   = msg_index(round_a);
   assign bit_len = {blocks_ff, fill_ff, 3'b000};

   always_comb begin
      case (fill_ff[1:0])
         2'd0:    pad_word = {24'h0, PadMarker};
         2'd1:    pad_word = {16'h0, PadMarker, acc_ff[7:0]};
         2'd2:    pad_word = {8'h0, PadMarker, acc_ff[15:0]};
         2'd3:    pad_word = {PadMarker, acc_ff[23:0]};
         default: pad_word = {24'h0, PadMarker};
      endcase
   end

   always_comb begin
      use_mem_in = 1'b0;
      alt_in     = '0;
      if (kind_ff == BLK_DATA) begin
         use_mem_in = 1'b1;
      end else if (kind_ff != BLK_LEN_ONLY && idx_a < fill_ff[5:2]) begin
         use_mem_in = 1'b1;
      end else if (kind_ff != BLK_LEN_ONLY && idx_a == fill_ff[5:2]) begin
         alt_in = pad_word;
      end else if (kind_ff != BLK_PAD_EXTRA && idx_a == 4'd14) begin
         alt_in = bit_len[31:0];
      end else if (kind_ff != BLK_PAD_EXTRA && idx_a == 4'd15) begin
         alt_in = bit_len[63:32];
      end
   end

   assign w_b    = use_mem_ff ? rd_ff : alt_ff;
   assign a_src  = (cnt_ff == 7'd1) ? a_ff : d_ff;
   assign pre_in = a_src + w_b + RoundAdd[round_b];
   assign f_c    = round_fn(b_ff, c_ff, d_ff, round_c[5:4]);
   assign t_c    = rotl(pre_ff + f_c, RotAmount[{round_c[5:4], round_c[1:0]}]) + b_ff;

   assign sum[0] = chain_ff[0] + a_ff;
   assign sum[1] = chain_ff[1] + b_ff;
   assign sum[2] = chain_ff[2] + c_ff;
   assign sum[3] = chain_ff[3] + d_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= BLK_DATA;
         cnt_ff       <= '0;
         pend_last_ff <= 1'b0;
         fill_ff      <= '0;
         blocks_ff    <= '0;
         chain_ff     <= InitVector;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !emit) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_tuser) begin
                     fill_ff <= fill_in;
                  end
                  if (start) begin
                     state_ff <= ST_RUN;
                     cnt_ff   <= '0;
                  end
                  if (req_tuser && fill_ff == 6'h3f) begin
                     kind_ff      <= BLK_DATA;
                     pend_last_ff <= req_tlast;
                  end else if (req_tlast) begin
                     kind_ff <= (n_eff <= PadLenLimit) ? BLK_PAD_LAST : BLK_PAD_EXTRA;
                  end
               end
            end
            ST_RUN: begin
               if (!at_final) begin
                  cnt_ff <= cnt_ff + 7'd1;
               end else begin
                  case (kind_ff)
                     BLK_DATA: begin
                        chain_ff  <= sum;
                        blocks_ff <= blocks_ff + 55'd1;
                        if (pend_last_ff) begin
                           kind_ff      <= BLK_PAD_LAST;
                           pend_last_ff <= 1'b0;
                           cnt_ff       <= '0;
                        end else begin
                           state_ff <= ST_IDLE;
                        end
                     end
                     BLK_PAD_EXTRA: begin
                        chain_ff <= sum;
                        kind_ff  <= BLK_LEN_ONLY;
                        cnt_ff   <= '0;
                     end
                     default: begin
                        if (emit) begin
                           rsp_valid_ff <= 1'b1;
                           rsp_data_ff  <= {sum[3], sum[2], sum[1], sum[0]};
                           chain_ff     <= InitVector;
                           fill_ff      <= '0;
                           blocks_ff    <= '0;
                           state_ff     <= ST_IDLE;
                        end
                     end
                  endcase
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      pre_ff     <= pre_in;
      use_mem_ff <= use_mem_in;
      alt_ff     <= alt_in;
      if (start) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
      end else if (restart) begin
         a_ff <= sum[0];
         b_ff <= sum[1];
         c_ff <= sum[2];
         d_ff <= sum[3];
      end else if (round_active) begin
         a_ff <= d_ff;
         d_ff <= c_ff;
         c_ff <= b_ff;
         b_ff <= t_c;
      end
      if (accept && req_tuser) begin
         case (fill_ff[1:0])
            2'd0:    acc_ff[7:0]   <= req_tdata;
            2'd1:    acc_ff[15:8]  <= req_tdata;
            2'd2:    acc_ff[23:16] <= req_tdata;
            default: acc_ff        <= acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_tuser && fill_ff[1:0] == 2'd3) begin
         mem[fill_ff[5:2]] <= {req_tdata, acc_ff};
      end
      rd_ff <= mem[idx_a];
   end

endmodule

// File: src/md5sh_checker.sv
// ----------------------------------------------------------------------------
// MD5 stream hash checker
// Watches the ports of the hash unit and checks its handshake behaviour.
// ----------------------------------------------------------------------------
module md5sh_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [7:0]   req_tdata,
   input logic         req_tuser,
   input logic         req_tlast,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata
);

   // A digest beat that is stalled keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("digest beat changed while stalled");

   // The unit is busy compressing right after a last beat.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("ready after a last beat");

   // An empty beat that is not last leaves the unit ready.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser && !req_tlast |=> req_tready)
      else $error("empty beat made the unit busy");

   // No digest beat is pending after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("digest beat pending after reset");

endmodule

bind md5_stream_hash_unit md5sh_checker u_md5sh_checker (.*);
